FILE: design/mps_pkg.sv
// ----------------------------------------------------------------------------
// mps_pkg
// Types, constants and helpers shared by the multicast prediction scoreboard.
// ----------------------------------------------------------------------------
package mps_pkg;

   localparam int MaskW       = 16;
   localparam int NodeW       = 4;
   localparam int OtherW      = 4;
   localparam int FieldW      = 32;
   localparam int IncW        = 6;
   localparam int KindCount   = 3;
   localparam int NumCounters = 12;

   localparam int PerfectOwnerL1 = 3;
   localparam int PerfectBase    = 2;

   typedef enum logic [1:0] {
      KIND_GETS = 2'd0,
      KIND_GETX = 2'd1,
      KIND_PUTX = 2'd2
   } kind_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [NodeW-1:0]  requester;
      logic [MaskW-1:0]  predicted_mask;
      logic [OtherW-1:0] predicted_other;
      logic [MaskW-1:0]  sharer_mask;
      logic              owner_present;
      logic              owner_is_l2;
      logic [NodeW-1:0]  owner_node;
   } item_type;

   typedef struct packed {
      logic [KindCount-1:0] req_inc;
      logic [KindCount-1:0] acc_inc;
      logic [KindCount-1:0] l2_inc;
      logic [IncW-1:0]      predicted;
      logic [IncW-1:0]      extra;
      logic [IncW-1:0]      perfect;
   } event_type;

   function automatic logic [IncW-1:0] popcount16(input logic [MaskW-1:0] x);
      logic [IncW-1:0] total;
      logic [2:0]      nib;
      total = '0;
      for (int n = 0; n < MaskW / 4; n++) begin
         nib = 3'(x[4*n]) + 3'(x[4*n+1]) + 3'(x[4*n+2]) + 3'(x[4*n+3]);
         total = total + IncW'(nib);
      end
      return total;
   endfunction

endpackage

FILE: design/multicast_prediction_scoreboard.sv
// ----------------------------------------------------------------------------
// multicast_prediction_scoreboard
// Saturating event counters for a multicast destination-set predictor.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    one coherence request
//   rsp      out        rsp_valid/stall    all twelve counters after it
//
// One request per cycle sustained while req_stall is low; a request passes
// through the input register, then the counters (also the result register).
// The counters only advance when the result slot is free or being taken,
// so a stalled result holds its values; req_stall rises only when both
// stages are full and rsp_stall is high.
// Synchronous reset clears all counters and both valid flags.
// ----------------------------------------------------------------------------
module multicast_prediction_scoreboard
   import mps_pkg::*;
#(
   parameter int NUM_L1       = 16,
   parameter int COUNTER_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_kind,
   input  logic [NodeW-1:0]  req_requester,
   input  logic [MaskW-1:0]  req_predicted_mask,
   input  logic [OtherW-1:0] req_predicted_other,
   input  logic [MaskW-1:0]  req_sharer_mask,
   input  logic              req_owner_present,
   input  logic              req_owner_is_l2,
   input  logic [NodeW-1:0]  req_owner_node,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [FieldW-1:0] rsp_gets_total,
   output logic [FieldW-1:0] rsp_getx_total,
   output logic [FieldW-1:0] rsp_putx_total,
   output logic [FieldW-1:0] rsp_nodes_predicted_total,
   output logic [FieldW-1:0] rsp_extra_nodes_total,
   output logic [FieldW-1:0] rsp_perfect_nodes_total,
   output logic [FieldW-1:0] rsp_gets_accurate,
   output logic [FieldW-1:0] rsp_getx_accurate,
   output logic [FieldW-1:0] rsp_putx_accurate,
   output logic [FieldW-1:0] rsp_gets_by_l2,
   output logic [FieldW-1:0] rsp_getx_by_l2,
   output logic [FieldW-1:0] rsp_putx_by_l2
);

   item_type              item_ff;
   logic                  in_valid_ff;
   logic                  in_valid_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic                  advance;
   event_type             ev;
   logic [IncW-1:0]       inc [NumCounters];
   logic [COUNTER_BITS-1:0] cnt [NumCounters];

   assign advance   = in_valid_ff & ~(rsp_valid_ff & rsp_stall);
   assign req_stall = in_valid_ff & rsp_valid_ff & rsp_stall;

   always_comb begin
      in_valid_in  = req_stall ? in_valid_ff : req_valid;
      rsp_valid_in = advance | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff.kind            <= req_kind;
         item_ff.requester       <= req_requester;
         item_ff.predicted_mask  <= req_predicted_mask;
         item_ff.predicted_other <= req_predicted_other;
         item_ff.sharer_mask     <= req_sharer_mask;
         item_ff.owner_present   <= req_owner_present;
         item_ff.owner_is_l2     <= req_owner_is_l2;
         item_ff.owner_node      <= req_owner_node;
      end
   end

   mps_eval #(
      .NUM_L1 (NUM_L1)
   ) u_eval (
      .item (item_ff),
      .ev   (ev)
   );

   always_comb begin
      for (int k = 0; k < KindCount; k++) begin
         inc[k]                 = IncW'(ev.req_inc[k]);
         inc[2*KindCount + k]   = IncW'(ev.acc_inc[k]);
         inc[3*KindCount + k]   = IncW'(ev.l2_inc[k]);
      end
      inc[KindCount]     = ev.predicted;
      inc[KindCount + 1] = ev.extra;
      inc[KindCount + 2] = ev.perfect;
   end

   for (genvar g = 0; g < NumCounters; g++) begin : g_counter
      mps_counter #(
         .WIDTH (COUNTER_BITS),
         .INC_W (IncW)
      ) u_counter (
         .clock  (clock),
         .reset  (reset),
         .enable (advance),
         .inc    (inc[g]),
         .count  (cnt[g])
      );
   end

   assign rsp_valid                 = rsp_valid_ff;
   assign rsp_gets_total            = FieldW'(cnt[0]);
   assign rsp_getx_total            = FieldW'(cnt[1]);
   assign rsp_putx_total            = FieldW'(cnt[2]);
   assign rsp_nodes_predicted_total = FieldW'(cnt[3]);
   assign rsp_extra_nodes_total     = FieldW'(cnt[4]);
   assign rsp_perfect_nodes_total   = FieldW'(cnt[5]);
   assign rsp_gets_accurate         = FieldW'(cnt[6]);
   assign rsp_getx_accurate         = FieldW'(cnt[7]);
   assign rsp_putx_accurate         = FieldW'(cnt[8]);
   assign rsp_gets_by_l2            = FieldW'(cnt[9]);
   assign rsp_getx_by_l2            = FieldW'(cnt[10]);
   assign rsp_putx_by_l2            = FieldW'(cnt[11]);

endmodule

FILE: design/mps_eval.sv
// ----------------------------------------------------------------------------
// mps_eval
// Classifies one registered request into counter increments.
// ----------------------------------------------------------------------------
module mps_eval
   import mps_pkg::*;
#(
   parameter int NUM_L1 = 16
) (
   input  item_type  item,
   output event_type ev
);

   logic [MaskW-1:0]     node_mask;
   logic [MaskW-1:0]     pred;
   logic [MaskW-1:0]     shr;
   logic [MaskW-1:0]     req_bit;
   logic [MaskW-1:0]     own_bit;
   logic [MaskW-1:0]     cand;
   logic                 owner_l1;
   logic                 sharer_ok;
   logic [IncW-1:0]      perfect;
   logic [KindCount-1:0] kind_hot;

   always_comb begin
      for (int i = 0; i < MaskW; i++) begin
         node_mask[i] = (i < NUM_L1);
      end
   end

   always_comb begin
      pred      = item.predicted_mask & node_mask;
      shr       = item.sharer_mask & node_mask;
      owner_l1  = item.owner_present & ~item.owner_is_l2;
      req_bit   = MaskW'(1) << item.requester;
      own_bit   = owner_l1 ? ((MaskW'(1) << item.owner_node) & node_mask) : '0;
      cand      = pred & ~req_bit;
      perfect   = owner_l1 ? IncW'(PerfectOwnerL1) : IncW'(PerfectBase);
      sharer_ok = 1'b1;
      kind_hot  = '0;
      case (kind_type'(item.kind))
         KIND_GETS: begin
            kind_hot[KIND_GETS] = 1'b1;
            cand = cand & ~own_bit;
         end
         KIND_GETX: begin
            kind_hot[KIND_GETX] = 1'b1;
            cand      = cand & ~own_bit & ~shr;
            perfect   = perfect + popcount16(shr);
            sharer_ok = ((shr & ~pred) == '0);
         end
         KIND_PUTX: begin
            kind_hot[KIND_PUTX] = 1'b1;
            cand      = cand & ~shr;
            perfect   = perfect + popcount16(shr);
            sharer_ok = ((shr & ~pred) == '0);
         end
         default: begin
            kind_hot = '0;
         end
      endcase
   end

   always_comb begin
      ev = '0;
      if (kind_hot != '0) begin
         ev.req_inc   = kind_hot;
         ev.predicted = popcount16(pred) + IncW'(item.predicted_other);
         ev.extra     = popcount16(cand);
         ev.perfect   = perfect;
         if (sharer_ok) begin
            if (!owner_l1) begin
               ev.acc_inc = kind_hot;
               ev.l2_inc  = kind_hot;
            end else if ((pred & own_bit) != '0) begin
               ev.acc_inc = kind_hot;
            end
         end
      end
   end

endmodule

FILE: design/mps_counter.sv
// ----------------------------------------------------------------------------
// mps_counter
// Saturating event counter with a narrow increment.
// ----------------------------------------------------------------------------
module mps_counter #(
   parameter int WIDTH = 32,
   parameter int INC_W = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  logic [INC_W-1:0] inc,
   output logic [WIDTH-1:0] count
);

   logic [WIDTH-1:0] count_ff;
   logic [WIDTH-1:0] count_in;
   logic [WIDTH:0]   sum;

   always_comb begin
      sum      = {1'b0, count_ff} + (WIDTH+1)'(inc);
      count_in = sum[WIDTH] ? '1 : sum[WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (enable) begin
         count_ff <= count_in;
      end
   end

   assign count = count_ff;

endmodule

FILE: design/mps_checker.sv
// ----------------------------------------------------------------------------
// mps_checker
// Port-level checks for the multicast prediction scoreboard.
// ----------------------------------------------------------------------------
module mps_checker
   import mps_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [FieldW-1:0] rsp_gets_total,
   input logic [FieldW-1:0] rsp_getx_total,
   input logic [FieldW-1:0] rsp_putx_total,
   input logic [FieldW-1:0] rsp_extra_nodes_total
);

   // hold a stalled transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_gets_total) &&
         $stable(rsp_extra_nodes_total))
      else $error("stalled result changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // at most one request kind advances per cycle
   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> $countones({rsp_gets_total != $past(rsp_gets_total),
         rsp_getx_total != $past(rsp_getx_total),
         rsp_putx_total != $past(rsp_putx_total)}) <= 1)
      else $error("more than one request total advanced");

   // a change in the GETS or extra-node total always comes with a presented result
   a_change_valid: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && (rsp_extra_nodes_total != $past(rsp_extra_nodes_total) ||
         rsp_gets_total != $past(rsp_gets_total)) |-> rsp_valid)
      else $error("counters advanced without a result");

endmodule

bind multicast_prediction_scoreboard mps_checker u_mps_checker (.*);
